FILE: sv/fda_pkg.sv
// shared types, constants and helpers for the fixed-point to decimal text converter
`default_nettype none
package fda_pkg;

  localparam int VALUE_W  = 48;
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 4;
  localparam int MAX_CHARS = 15;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2e;

  // what the character sequencer needs to lay out one text
  typedef struct packed {
    logic             neg;
    logic [3:0]       ndig;
    logic             has_frac;
    logic [LEN_W-1:0] length;
  } emit_cmd_t;

  // ten to the power n, evaluated at elaboration
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < n; i++) begin
      acc = acc * 64'd10;
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

FILE: sv/fda_dabble.sv
// bit-serial shift-and-add-three unit turning the integer part into decimal digits
`default_nettype none
module fda_dabble #(
  parameter int INT_DIGITS = 8,
  parameter int IPART_W    = 28
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [IPART_W-1:0]      ipart,
  output logic                         done,
  output logic [4*INT_DIGITS-1:0]      bcd,
  output logic [3:0]                   ndig
);
  import fda_pkg::*;

  localparam int CNT_W = $clog2(IPART_W + 1);
  localparam int BCD_W = 4 * INT_DIGITS;
  localparam logic [63:0] LIMIT = pow10(INT_DIGITS);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IPART_W-1:0] shift_r;
  logic [BCD_W-1:0]  bcd_r;
  logic              ovf_r;
  logic [BCD_W-1:0]  adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < INT_DIGITS; d++) begin
      adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? (bcd_r[d*4 +: 4] + 4'd3)
                                                : bcd_r[d*4 +: 4];
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(IPART_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift datapath; digits past the top one fall off, leaving the value mod 10^n
  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= ipart;
      bcd_r   <= '0;
      ovf_r   <= (64'(ipart) >= LIMIT);
    end else if (busy_r) begin
      shift_r <= shift_r << 1;
      bcd_r   <= {adj[BCD_W-2:0], shift_r[IPART_W-1]};
    end
  end

  // digit count: all digits when high ones were dropped, else up to the top nonzero one
  always_comb begin
    ndig = 4'd1;
    if (ovf_r) begin
      ndig = 4'(INT_DIGITS);
    end else begin
      for (int d = 0; d < INT_DIGITS; d++) begin
        if (bcd_r[d*4 +: 4] != 4'd0) begin
          ndig = 4'(d + 1);
        end
      end
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule
`default_nettype wire

FILE: sv/fda_emit.sv
// character sequencer with a shared multiply-by-ten step and the output register
`default_nettype none
module fda_emit #(
  parameter int INT_DIGITS = 8,
  parameter int FRAC_BITS  = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire fda_pkg::emit_cmd_t          cmd,
  input  wire logic [4*INT_DIGITS-1:0]     bcd,
  input  wire logic [FRAC_BITS-1:0]        frac,
  output logic                             done,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [fda_pkg::CHAR_W-1:0]       out_character,
  output logic [fda_pkg::LEN_W-1:0]        out_text_length,
  output logic                             out_last
);
  import fda_pkg::*;

  localparam int IDX_W = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;

  logic                 active_r;
  logic [LEN_W-1:0]     pos_r;
  logic                 sign_pend_r;
  logic [3:0]           dig_left_r;
  logic                 dot_pend_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [LEN_W-1:0]     len_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic [LEN_W-1:0]     out_len_r;
  logic                 out_last_r;

  logic                 adv;
  logic                 is_last;
  logic [CHAR_W-1:0]    char_nxt;
  logic [FRAC_BITS+3:0] prod;
  logic [IDX_W-1:0]     dig_idx;
  logic [3:0]           dig_sel;
  logic [3:0]           dig_left_m1;

  assign adv     = active_r && (!out_valid_r || !out_stall);
  assign is_last = (pos_r == len_r - 1'b1);

  // remaining fraction times ten as shift-and-add
  assign prod = ({4'd0, frac_r} << 3) + ({4'd0, frac_r} << 1);

  assign dig_left_m1 = dig_left_r - 1'b1;
  assign dig_idx     = dig_left_m1[IDX_W-1:0];
  assign dig_sel     = bcd[dig_idx*4 +: 4];

  // pick the next character in text order
  always_comb begin
    if (sign_pend_r) begin
      char_nxt = ASCII_MINUS;
    end else if (dig_left_r != 4'd0) begin
      char_nxt = ASCII_ZERO + {4'd0, dig_sel};
    end else if (dot_pend_r) begin
      char_nxt = ASCII_POINT;
    end else begin
      char_nxt = ASCII_ZERO + {4'd0, prod[FRAC_BITS+3:FRAC_BITS]};
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= '0;
      sign_pend_r <= 1'b0;
      dig_left_r  <= '0;
      dot_pend_r  <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        active_r    <= 1'b1;
        pos_r       <= '0;
        sign_pend_r <= cmd.neg;
        dig_left_r  <= cmd.ndig;
        dot_pend_r  <= cmd.has_frac;
        len_r       <= cmd.length;
      end else if (adv) begin
        pos_r <= pos_r + 1'b1;
        if (is_last) begin
          active_r <= 1'b0;
        end
        if (sign_pend_r) begin
          sign_pend_r <= 1'b0;
        end else if (dig_left_r != 4'd0) begin
          dig_left_r <= dig_left_m1;
        end else if (dot_pend_r) begin
          dot_pend_r <= 1'b0;
        end
      end
      // output register holds while stalled
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      frac_r <= frac;
    end else if (adv && !sign_pend_r && dig_left_r == 4'd0 && !dot_pend_r) begin
      frac_r <= prod[FRAC_BITS-1:0];
    end
    if (adv) begin
      out_char_r <= char_nxt;
      out_len_r  <= len_r;
      out_last_r <= is_last;
    end
  end

  assign done            = adv && is_last;
  assign out_valid       = out_valid_r;
  assign out_character   = out_char_r;
  assign out_text_length = out_len_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

FILE: sv/fixed_to_decimal_ascii.sv
// top level: signed fixed-point number in, decimal ASCII characters out
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   in_value (48-bit signed, FRAC_BITS fraction bits)
//  out_     output     out_valid / out_stall out_character, out_text_length, out_last
//
// an item gives up to 15 characters; the bit-serial digit conversion takes the bulk of
// the time spent on it
// one character leaves per cycle while out_stall is low; a stalled character holds
// in_stall stays high from the transfer of an item until its last character is registered
// synchronous active-low reset clears the sequencers and the output valid
`default_nettype none
module fixed_to_decimal_ascii #(
  parameter int INT_DIGITS  = 8,
  parameter int FRAC_DIGITS = 5,
  parameter int FRAC_BITS   = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [fda_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [fda_pkg::CHAR_W-1:0]         out_character,
  output logic [fda_pkg::LEN_W-1:0]          out_text_length,
  output logic                               out_last
);
  import fda_pkg::*;

  localparam int IPART_W = VALUE_W - FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_CONV  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 neg_r;
  logic [VALUE_W-1:0]   mag_r;
  logic                 accept;
  logic                 conv_done;
  logic                 emit_done;
  logic [4*INT_DIGITS-1:0] bcd;
  logic [3:0]           ndig;
  emit_cmd_t            cmd;
  logic                 has_frac;
  logic [4:0]           len_full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_START;
      S_START: state_nxt = S_CONV;
      S_CONV:  if (conv_done) state_nxt = S_EMIT;
      S_EMIT:  if (emit_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // magnitude of the transferred value; the most negative value gives 2^47 exactly
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= in_value[VALUE_W-1];
      mag_r <= in_value[VALUE_W-1] ? (~in_value + 1'b1) : in_value;
    end
  end

  // text layout once the integer digits are known
  assign has_frac = (mag_r[FRAC_BITS-1:0] != '0);
  assign len_full = 5'(neg_r) + 5'(ndig) + (has_frac ? 5'(FRAC_DIGITS + 1) : 5'd0);

  always_comb begin
    cmd.neg      = neg_r;
    cmd.ndig     = ndig;
    cmd.has_frac = has_frac;
    cmd.length   = (len_full > 5'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : len_full[LEN_W-1:0];
  end

  fda_dabble #(
    .INT_DIGITS (INT_DIGITS),
    .IPART_W    (IPART_W)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_START),
    .ipart (mag_r[VALUE_W-1:FRAC_BITS]),
    .done  (conv_done),
    .bcd   (bcd),
    .ndig  (ndig)
  );

  fda_emit #(
    .INT_DIGITS (INT_DIGITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           ((state_r == S_CONV) && conv_done),
    .cmd             (cmd),
    .bcd             (bcd),
    .frac            (mag_r[FRAC_BITS-1:0]),
    .done            (emit_done),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_character   (out_character),
    .out_text_length (out_text_length),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

FILE: bench/tb.sv
// self-checking bench for the fixed-point to decimal text converter
module tb;
  import fda_pkg::*;

  localparam int INT_DIGITS  = 8;
  localparam int FRAC_DIGITS = 5;
  localparam int FRAC_BITS   = 20;
  localparam int IP_W        = VALUE_W - FRAC_BITS;
  localparam int RANDOM_NUMS = 320;
  localparam int CALM_NUMS   = 60;

  // one expected character of a number's text
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              is_last;
    int                number;
  } text_char_t;

  // decimal text predictor and in-order character checker
  class decimal_text_board;
    text_char_t pending_chars[$];
    int errors;
    int numbers;
    int negatives;
    int truncated;
    int chars_checked;

    // lay out the text of one accepted number and queue its characters
    function void note_value(input logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] ipart;
      logic [63:0]        frac;
      logic [3:0]         digits [INT_DIGITS];
      logic [CHAR_W-1:0]  txt [$];
      int                 nd;
      int                 count;
      text_char_t         e;
      mag   = v[VALUE_W-1] ? (~v + 1'b1) : v;
      ipart = mag >> FRAC_BITS;
      frac  = 64'(mag[FRAC_BITS-1:0]);
      nd    = 0;
      numbers++;
      if (v[VALUE_W-1]) negatives++;
      if (ipart >= 100_000_000) truncated++;
      // integer digits, least significant first, high ones dropped
      if (ipart == 0) begin
        digits[0] = 4'd0;
        nd = 1;
      end else begin
        while (ipart != 0 && nd < INT_DIGITS) begin
          digits[nd] = 4'(ipart % 10);
          ipart = ipart / 10;
          nd++;
        end
      end
      if (v[VALUE_W-1]) txt.push_back(ASCII_MINUS);
      for (int i = nd - 1; i >= 0; i--) txt.push_back(ASCII_ZERO + digits[i]);
      // truncated fraction digits by repeated times ten
      if (frac != 0) begin
        txt.push_back(ASCII_POINT);
        for (int i = 0; i < FRAC_DIGITS; i++) begin
          frac = frac * 10;
          txt.push_back(ASCII_ZERO + 8'(frac >> FRAC_BITS));
          frac = frac & ((64'd1 << FRAC_BITS) - 1);
        end
      end
      count = (txt.size() > MAX_CHARS) ? MAX_CHARS : txt.size();
      for (int i = 0; i < count; i++) begin
        e.ch      = txt[i];
        e.len     = (txt.size() > 15) ? 4'd15 : LEN_W'(txt.size());
        e.is_last = (i == count - 1);
        e.number  = numbers;
        pending_chars.push_back(e);
      end
    endfunction

    // compare one character transfer with the oldest expectation
    function void check_char(input logic [CHAR_W-1:0] ch, input logic [LEN_W-1:0] len,
                             input logic is_last);
      text_char_t e;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected character %h len=%0d last=%0b with no text pending",
                   ch, len, is_last);
        return;
      end
      e = pending_chars.pop_front();
      if (ch !== e.ch || len !== e.len || is_last !== e.is_last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch in number %0d: expected ch=%h len=%0d last=%0b, ",
                    "got ch=%h len=%0d last=%0b"},
                   e.number, e.ch, e.len, e.is_last, ch, len, is_last);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [CHAR_W-1:0]         out_character;
  logic [LEN_W-1:0]          out_text_length;
  logic                      out_last;
  bit                        calm;

  decimal_text_board board = new();

  // corner values: zero, extremes, truncation edges, dropped digits, negative fractions
  logic [VALUE_W-1:0] corner_values [] = '{
    48'd0,
    48'd1,
    -48'd1,
    48'd1 << 20,
    -(48'd1 << 20),
    48'd1 << 19,
    -(48'd1 << 19),
    (48'd1 << 20) - 48'd1,
    48'h7FFF_FFFF_FFFF,
    48'h8000_0000_0000,
    48'd100_000_000 << 20,
    (48'd100_000_000 << 20) - 48'd1,
    -((48'd100_000_000 << 20) - 48'd1),
    48'd134_217_727 << 20,
    -(48'd10 << 20),
    (48'd12_345_678 << 20) | 48'd123_456,
    -((48'd7 << 20) | 48'h4_0000),
    48'd3 << 18,
    48'd1 << 46,
    -48'd5,
    48'd120_000_305 << 20
  };

  fixed_to_decimal_ascii #(
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGITS(FRAC_DIGITS),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_character  (out_character),
    .out_text_length(out_text_length),
    .out_last       (out_last)
  );

  always #10 clk = ~clk;

  // random value mix weighted toward digit-count and fraction edges
  function automatic logic [VALUE_W-1:0] random_value();
    logic [IP_W-1:0]      ip;
    logic [FRAC_BITS-1:0] fr;
    logic [VALUE_W-1:0]   mag;
    int                   kind;
    int                   k;
    kind = $urandom_range(0, 9);
    ip   = '0;
    fr   = '0;
    case (kind)
      0, 1: begin
        return VALUE_W'({$urandom(), $urandom()});
      end
      2, 3: begin
        ip = IP_W'($urandom_range(0, (kind == 2) ? 99 : 99_999_999));
      end
      4, 5: begin
        ip = IP_W'($urandom_range(0, 999));
        fr = FRAC_BITS'($urandom_range(0, (1 << FRAC_BITS) - 1));
      end
      6: begin
        fr = FRAC_BITS'($urandom_range(0, (1 << FRAC_BITS) - 1));
      end
      7: begin
        k  = $urandom_range(0, 8);
        ip = IP_W'(1);
        repeat (k) ip = IP_W'(ip * 10);
        ip = IP_W'(ip + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 1)) fr = FRAC_BITS'($urandom_range(0, (1 << FRAC_BITS) - 1));
      end
      8: begin
        ip = IP_W'($urandom_range(100_000_000, 134_217_727));
        if ($urandom_range(0, 1)) fr = FRAC_BITS'($urandom_range(0, (1 << FRAC_BITS) - 1));
      end
      default: begin
        ip = IP_W'($urandom_range(0, 9));
        fr = $urandom_range(0, 1) ? FRAC_BITS'($urandom_range(1, 15))
                                  : FRAC_BITS'((1 << FRAC_BITS) - 1 - $urandom_range(0, 15));
      end
    endcase
    mag = {ip, fr};
    if ($urandom_range(0, 1)) mag = -mag;
    return mag;
  endfunction

  // offer one number, with an optional idle burst first, until it transfers
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_value <= VALUE_W'({$urandom(), $urandom()});
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_value(v);
  endtask

  // hold the input quiet until every queued character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_chars.size() != 0) @(posedge clk);
  endtask

  // result side: stall bursts between free-running stretches
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // check every character transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_char(out_character, out_text_length, out_last);
  end

  // main sequence: reset, corner values, random values, drain
  initial begin
    calm = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corner_values[i]) send_value(corner_values[i]);
    wait_drained();
    for (int n = 0; n < RANDOM_NUMS; n++) begin
      if (n == RANDOM_NUMS - CALM_NUMS) calm = 1'b1;
      if (n == RANDOM_NUMS / 2) wait_drained();
      send_value(random_value());
    end
    wait_drained();
    repeat (80) @(posedge clk);
    $display("converted %0d numbers (%0d negative, %0d with dropped integer digits)",
             board.numbers, board.negatives, board.truncated);
    $display("checked %0d characters, %0d mismatches", board.chars_checked, board.errors);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
